>>> hw/rtl/sndig_pkg.sv
// ----------------------------------------------------------------------------
// sndig_pkg
// Shared types, codes and defaults of the strided n-d index generator.
// ----------------------------------------------------------------------------
package sndig_pkg;

  localparam int MAX_DIMS_DEF   = 4;
  localparam int INDEX_BITS_DEF = 16;
  localparam int QUEUE_DEPTH    = 2;
  localparam int DIM_SLOTS      = 4;
  localparam int CFG_IDX_W      = 3;
  localparam int CFG_DATA_W     = 64;

  // request codes
  localparam logic [1:0] REQ_RESTART   = 2'd0;
  localparam logic [1:0] REQ_STEP      = 2'd1;
  localparam logic [1:0] REQ_LINEARIZE = 2'd2;

  // status codes
  localparam logic [1:0] STAT_OK       = 2'd0;
  localparam logic [1:0] STAT_PAST_END = 2'd1;
  localparam logic [1:0] STAT_RANGE    = 2'd2;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_NUM_DIMS = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_DIM0     = 3'd1;

  typedef struct packed {
    logic [1:0]  req_type;
    logic [15:0] index_0;
    logic [15:0] index_1;
    logic [15:0] index_2;
    logic [15:0] index_3;
    logic        check_range;
  } in_item_t;

  typedef struct packed {
    logic [15:0] out_index_0;
    logic [15:0] out_index_1;
    logic [15:0] out_index_2;
    logic [15:0] out_index_3;
    logic [63:0] linear_offset;
    logic [1:0]  status;
    logic        last;
  } out_item_t;

  // classified item handed from front to back
  typedef struct packed {
    logic [DIM_SLOTS-1:0][15:0] tuple;
    logic [1:0]                 status;
    logic                       last;
    logic                       do_lin;
  } job_t;

endpackage

>>> hw/rtl/sndig_front.sv
// ----------------------------------------------------------------------------
// sndig_front
// Accepts items, keeps the iterator state and builds one job per item.
// ----------------------------------------------------------------------------
module sndig_front #(
  parameter int MAX_DIMS   = sndig_pkg::MAX_DIMS_DEF,
  parameter int INDEX_BITS = sndig_pkg::INDEX_BITS_DEF,
  parameter int CW         = $clog2(MAX_DIMS + 1)
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  input  sndig_pkg::in_item_t          in_data,
  input  logic                         q_full,
  input  logic [MAX_DIMS-1:0][63:0]    geom,
  input  logic [CW-1:0]                n_used,
  output logic                         push,
  output sndig_pkg::job_t              job
);
  import sndig_pkg::*;

  logic [MAX_DIMS-1:0][INDEX_BITS-1:0] tuple_r, tuple_nxt;
  logic                                finished_r, finished_nxt;
  logic [DIM_SLOTS-1:0][15:0]          idx_in;

  assign push = in_valid && !q_full;

  assign idx_in[0] = in_data.index_0;
  assign idx_in[1] = in_data.index_1;
  assign idx_in[2] = in_data.index_2;
  assign idx_in[3] = in_data.index_3;

  always_comb begin
    logic                  carry;
    logic                  bad;
    logic [INDEX_BITS:0]   v;
    logic [INDEX_BITS-1:0] t;
    job          = '0;
    tuple_nxt    = tuple_r;
    finished_nxt = finished_r;
    carry        = 1'b1;
    bad          = 1'b0;
    v            = '0;
    t            = '0;
    unique case (in_data.req_type)
      REQ_RESTART: begin
        for (int k = 0; k < MAX_DIMS; k++) begin
          if (CW'(k) < n_used) begin
            tuple_nxt[k] = geom[k][32 +: INDEX_BITS];
            job.tuple[k] = 16'(geom[k][32 +: INDEX_BITS]);
          end
        end
        finished_nxt = 1'b0;
        job.do_lin   = 1'b1;
      end
      REQ_STEP: begin
        if (finished_r) begin
          job.status = STAT_PAST_END;
        end else begin
          for (int k = 0; k < MAX_DIMS; k++) begin
            if (CW'(k) < n_used) job.tuple[k] = 16'(tuple_r[k]);
          end
          job.do_lin = 1'b1;
          // odometer: rightmost dimension in use first, carry ripples left
          for (int k = MAX_DIMS - 1; k >= 0; k--) begin
            if (CW'(k) < n_used && carry) begin
              v = {1'b0, tuple_r[k]} + {1'b0, geom[k][0 +: INDEX_BITS]};
              if (v > {1'b0, geom[k][16 +: INDEX_BITS]}) begin
                tuple_nxt[k] = geom[k][32 +: INDEX_BITS];
              end else begin
                tuple_nxt[k] = v[INDEX_BITS-1:0];
                carry        = 1'b0;
              end
            end
          end
          if (carry) begin
            finished_nxt = 1'b1;
            job.last     = 1'b1;
          end
        end
      end
      REQ_LINEARIZE: begin
        for (int k = 0; k < MAX_DIMS; k++) begin
          if (CW'(k) < n_used) begin
            t            = idx_in[k][INDEX_BITS-1:0];
            job.tuple[k] = 16'(t);
            if (16'(t) >= geom[k][63:48]) bad = 1'b1;
          end
        end
        if (in_data.check_range && bad) job.status = STAT_RANGE;
        else                            job.do_lin = 1'b1;
      end
      default: begin
        job = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tuple_r    <= '0;
      finished_r <= 1'b1;
    end else if (push) begin
      tuple_r    <= tuple_nxt;
      finished_r <= finished_nxt;
    end
  end

endmodule

>>> hw/rtl/sndig_queue.sv
// ----------------------------------------------------------------------------
// sndig_queue
// Short register queue of jobs between the front and the back.
// ----------------------------------------------------------------------------
module sndig_queue #(
  parameter int DEPTH = sndig_pkg::QUEUE_DEPTH
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            push,
  input  sndig_pkg::job_t push_data,
  input  logic            pop,
  output sndig_pkg::job_t head,
  output logic            full,
  output logic            empty
);
  import sndig_pkg::*;

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int NW = $clog2(DEPTH + 1);

  job_t          mem_r [DEPTH];
  logic [PW-1:0] wr_ptr_r, rd_ptr_r;
  logic [NW-1:0] count_r;

  assign full  = (count_r == NW'(DEPTH));
  assign empty = (count_r == '0);
  assign head  = mem_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (push) mem_r[wr_ptr_r] <= push_data;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) wr_ptr_r <= (wr_ptr_r == PW'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
      if (pop)  rd_ptr_r <= (rd_ptr_r == PW'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
      if (push && !pop)      count_r <= count_r + 1'b1;
      else if (pop && !push) count_r <= count_r - 1'b1;
    end
  end

endmodule

>>> hw/rtl/sndig_back.sv
// ----------------------------------------------------------------------------
// sndig_back
// Row-major offset unit: one multiply-accumulate per dimension after the
// first, then the output register.
// ----------------------------------------------------------------------------
module sndig_back #(
  parameter int MAX_DIMS = sndig_pkg::MAX_DIMS_DEF,
  parameter int CW       = $clog2(MAX_DIMS + 1)
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  sndig_pkg::job_t           head,
  input  logic                      q_empty,
  output logic                      pop,
  input  logic [MAX_DIMS-1:0][63:0] geom,
  input  logic [CW-1:0]             n_used,
  output logic                      out_valid,
  input  logic                      out_stall,
  output sndig_pkg::out_item_t      out_data
);
  import sndig_pkg::*;

  job_t          job_r;
  logic [63:0]   off_r;
  logic [CW-1:0] cnt_r;
  logic          busy_r;
  logic          out_valid_r;
  out_item_t     out_r;

  logic [1:0]    sel;
  logic [15:0]   size_sel;
  logic [47:0]   prod_lo;
  logic [31:0]   prod_hi;
  logic [63:0]   mac;
  logic          lin_done, out_free, finish;

  assign sel = 2'(cnt_r);

  always_comb begin
    size_sel = '0;
    for (int k = 0; k < MAX_DIMS; k++) begin
      if (sel == 2'(k)) size_sel = geom[k][63:48];
    end
  end

  // 64x16 product split in two 32x16 halves, upper half wraps mod 2^64
  assign prod_lo = 48'(size_sel) * 48'(off_r[31:0]);
  assign prod_hi = 32'(size_sel) * off_r[63:32];
  assign mac     = {prod_hi, 32'b0} + 64'(prod_lo) + 64'(job_r.tuple[sel]);

  assign lin_done = !job_r.do_lin || (cnt_r >= n_used);
  assign out_free = !out_valid_r || !out_stall;
  assign finish   = busy_r && lin_done && out_free;
  assign pop      = !q_empty && (!busy_r || finish);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (pop)         busy_r <= 1'b1;
      else if (finish) busy_r <= 1'b0;
      if (finish)          out_valid_r <= 1'b1;
      else if (!out_stall) out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      job_r <= head;
      off_r <= 64'(head.tuple[0]);
      cnt_r <= CW'(1);
    end else if (busy_r && !lin_done) begin
      off_r <= mac;
      cnt_r <= cnt_r + 1'b1;
    end
    if (finish) begin
      out_r.out_index_0   <= job_r.tuple[0];
      out_r.out_index_1   <= job_r.tuple[1];
      out_r.out_index_2   <= job_r.tuple[2];
      out_r.out_index_3   <= job_r.tuple[3];
      out_r.linear_offset <= job_r.do_lin ? off_r : 64'd0;
      out_r.status        <= job_r.status;
      out_r.last          <= job_r.last;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

endmodule

>>> hw/rtl/strided_nd_index_generator.sv
// ----------------------------------------------------------------------------
// strided_nd_index_generator
// Strided n-d odometer with row-major linearizer.
// ----------------------------------------------------------------------------
//  channel | direction | ports                               | payload
//  in      | input     | in_valid, in_stall, in_data         | in_item_t
//  out     | output    | out_valid, out_stall, out_data      | out_item_t
//  cfg     | input     | cfg_we, cfg_index, cfg_wdata        | 64-bit register
//
//  the front takes one item per cycle while the two-entry job queue has room
//  the offset unit pops the next job only as it finishes the current one; it
//  does one load and n-1 multiply-accumulates (n = dimensions in use), and
//  items without an offset skip the multiply-accumulates
//  reset is synchronous, active low; no clearing pass is needed
//  out_stall holds the output register and the offset unit; the front
//  keeps accepting until the queue fills
// ----------------------------------------------------------------------------
module strided_nd_index_generator #(
  parameter int MAX_DIMS   = sndig_pkg::MAX_DIMS_DEF,
  parameter int INDEX_BITS = sndig_pkg::INDEX_BITS_DEF
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  sndig_pkg::in_item_t                 in_data,
  output logic                                out_valid,
  input  logic                                out_stall,
  output sndig_pkg::out_item_t                out_data,
  input  logic                                cfg_we,
  input  logic [sndig_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [sndig_pkg::CFG_DATA_W-1:0]    cfg_wdata
);
  import sndig_pkg::*;

  localparam int CW = $clog2(MAX_DIMS + 1);

  logic [2:0]                num_dims_r;
  logic [MAX_DIMS-1:0][63:0] geom_r;
  logic [CW-1:0]             n_used;
  logic                      push, pop, q_full, q_empty;
  job_t                      job, head;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      num_dims_r <= 3'd1;
      geom_r     <= '0;
    end else if (cfg_we) begin
      if (cfg_index == CFG_NUM_DIMS) num_dims_r <= cfg_wdata[2:0];
      for (int k = 0; k < MAX_DIMS; k++) begin
        if (cfg_index == CFG_DIM0 + CFG_IDX_W'(k)) geom_r[k] <= cfg_wdata;
      end
    end
  end

  // zero dimensions act as one, too many act as the maximum
  always_comb begin
    if (num_dims_r == 3'd0)                n_used = CW'(1);
    else if (num_dims_r > 3'(MAX_DIMS))    n_used = CW'(MAX_DIMS);
    else                                   n_used = CW'(num_dims_r);
  end

  assign in_stall = q_full;

  sndig_front #(
    .MAX_DIMS   (MAX_DIMS),
    .INDEX_BITS (INDEX_BITS),
    .CW         (CW)
  ) u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_data  (in_data),
    .q_full   (q_full),
    .geom     (geom_r),
    .n_used   (n_used),
    .push     (push),
    .job      (job)
  );

  sndig_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_data (job),
    .pop       (pop),
    .head      (head),
    .full      (q_full),
    .empty     (q_empty)
  );

  sndig_back #(
    .MAX_DIMS (MAX_DIMS),
    .CW       (CW)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .head      (head),
    .q_empty   (q_empty),
    .pop       (pop),
    .geom      (geom_r),
    .n_used    (n_used),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  // past-end steps carry no offset and never mark last
  a_past_end_clean: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.status == STAT_PAST_END |->
      out_data.linear_offset == 64'd0 && !out_data.last)
    else $error("past-end result carries data");

  // out of range items carry no offset
  a_range_no_offset: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.status == STAT_RANGE |-> out_data.linear_offset == 64'd0)
    else $error("range error with offset");

  // a wrap is only flagged on a good step
  a_last_ok: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.last |-> out_data.status == STAT_OK)
    else $error("last with error status");

  // a queue pop always has a job behind it
  a_pop_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> !q_empty)
    else $error("pop from empty queue");

endmodule

>>> sim/tb_strided_nd_index_generator.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_strided_nd_index_generator
// Self-checking bench for the strided n-d index generator. A queue-fed driver
// and a clocked monitor exercise restart, step, linearize and unknown items
// across many dimension settings, with random idling on both sides. Every
// result is compared with a cycle-free model of the odometer and linearizer.
// ----------------------------------------------------------------------------
module tb_strided_nd_index_generator;
  import sndig_pkg::*;

  localparam int STUCK_LIMIT = 4000;
  localparam int MAX_SHOWN   = 10;
  localparam int RAND_PHASES = 10;
  localparam int PHASE_ITEMS = 40;
  localparam int IDLE_PCT    = 34;
  localparam logic [1:0] REQ_UNKNOWN = 2'd3;

  logic                  clk       = 1'b0;
  logic                  rst_n     = 1'b0;
  logic                  in_valid  = 1'b0;
  logic                  in_stall;
  in_item_t              in_data   = '0;
  logic                  out_valid;
  logic                  out_stall = 1'b0;
  out_item_t             out_data;
  logic                  cfg_we    = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_wdata = '0;

  strided_nd_index_generator dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  in_item_t  pending_items[$];
  out_item_t expected_results[$];

  logic in_taken = 1'b0;
  logic hold_in  = 1'b0;
  logic calm     = 1'b0;

  int stuck_cycles = 0;
  int mismatches   = 0;
  int results_seen = 0;
  int cfg_writes   = 0;
  int n_restart    = 0;
  int n_step       = 0;
  int n_wrap       = 0;
  int n_past_end   = 0;
  int n_lin        = 0;
  int n_range      = 0;
  int n_unknown    = 0;

  // model copy of the block's registers and iterator
  logic [2:0]       ndims_reg;
  logic [3:0][63:0] geom_reg;
  logic [3:0][15:0] odo_tuple;
  logic             odo_done;

  // sizes as last written, used to aim linearize indices
  logic [15:0] plan_size[DIM_SLOTS];

  initial begin
    forever #1 clk = ~clk;
  end

  function automatic int dims_in_use();
    int n;
    n = int'(ndims_reg);
    if (n < 1) n = 1;
    if (n > MAX_DIMS_DEF) n = MAX_DIMS_DEF;
    return n;
  endfunction

  function automatic logic [63:0] row_major_offset(logic [3:0][15:0] t, int n);
    logic [63:0] off;
    off = {48'd0, t[0]};
    for (int i = 1; i < n; i++)
      off = {48'd0, t[i]} + {48'd0, geom_reg[i][63:48]} * off;
    return off;
  endfunction

  function automatic out_item_t pack_result(logic [3:0][15:0] t, int n, logic [63:0] off,
                                            logic [1:0] st, logic lst);
    out_item_t r;
    r.out_index_0   = t[0];
    r.out_index_1   = (n > 1) ? t[1] : 16'd0;
    r.out_index_2   = (n > 2) ? t[2] : 16'd0;
    r.out_index_3   = (n > 3) ? t[3] : 16'd0;
    r.linear_offset = off;
    r.status        = st;
    r.last          = lst;
    return r;
  endfunction

  function automatic out_item_t predict_index_result(in_item_t it);
    int               n;
    logic [3:0][15:0] t;
    logic [16:0]      v;
    logic             carry;
    logic             bad;
    out_item_t        r;
    n = dims_in_use();
    r = '0;
    case (it.req_type)
      REQ_RESTART: begin
        for (int i = 0; i < n; i++)
          odo_tuple[i] = geom_reg[i][47:32];
        odo_done = 1'b0;
        r = pack_result(odo_tuple, n, row_major_offset(odo_tuple, n), STAT_OK, 1'b0);
      end
      REQ_STEP: begin
        if (odo_done) begin
          r.status = STAT_PAST_END;
        end else begin
          r = pack_result(odo_tuple, n, row_major_offset(odo_tuple, n), STAT_OK, 1'b0);
          carry = 1'b1;
          // rightmost first, one bit wider so the sum cannot wrap before the compare
          for (int i = MAX_DIMS_DEF - 1; i >= 0; i--) begin
            if (carry && i < n) begin
              v = {1'b0, odo_tuple[i]} + {1'b0, geom_reg[i][15:0]};
              carry = 1'b0;
              if (v > {1'b0, geom_reg[i][31:16]}) begin
                v = {1'b0, geom_reg[i][47:32]};
                carry = 1'b1;
              end
              odo_tuple[i] = v[15:0];
            end
          end
          if (carry) begin
            odo_done = 1'b1;
            r.last   = 1'b1;
          end
        end
      end
      REQ_LINEARIZE: begin
        t   = {it.index_3, it.index_2, it.index_1, it.index_0};
        bad = 1'b0;
        for (int i = 0; i < n; i++)
          if (t[i] >= geom_reg[i][63:48]) bad = 1'b1;
        if (it.check_range && bad)
          r = pack_result(t, n, 64'd0, STAT_RANGE, 1'b0);
        else
          r = pack_result(t, n, row_major_offset(t, n), STAT_OK, 1'b0);
      end
      default: r = '0;
    endcase
    return r;
  endfunction

  function automatic string fmt_result(out_item_t r);
    return $sformatf("idx %h %h %h %h off %h status %0d last %0b", r.out_index_0,
                     r.out_index_1, r.out_index_2, r.out_index_3, r.linear_offset,
                     r.status, r.last);
  endfunction

  // driver: new item only once the previous one has been taken
  always @(negedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else if (!in_valid || in_taken) begin
      if (pending_items.size() != 0 && !hold_in &&
          (calm || $urandom_range(99) >= IDLE_PCT)) begin
        in_data  <= pending_items.pop_front();
        in_valid <= 1'b1;
      end else begin
        in_valid <= 1'b0;
      end
    end
    out_stall <= !calm && ($urandom_range(99) < IDLE_PCT);
  end

  // monitor: model update on every accepted item, check on every result
  always @(posedge clk) begin : monitor
    out_item_t pred;
    out_item_t want;
    if (!rst_n) begin
      ndims_reg = 3'd1;
      geom_reg  = '0;
      odo_tuple = '0;
      odo_done  = 1'b1;
      in_taken <= 1'b0;
    end else begin
      if (cfg_we) begin
        cfg_writes++;
        if (cfg_index == CFG_NUM_DIMS)
          ndims_reg = cfg_wdata[2:0];
        else if (cfg_index >= CFG_DIM0 && cfg_index < CFG_DIM0 + DIM_SLOTS)
          geom_reg[2'(cfg_index - CFG_DIM0)] = cfg_wdata;
      end
      in_taken <= in_valid && !in_stall;
      if (in_valid && !in_stall) begin
        pred = predict_index_result(in_data);
        expected_results = {expected_results, pred};
        case (in_data.req_type)
          REQ_RESTART:   n_restart++;
          REQ_STEP:      n_step++;
          REQ_LINEARIZE: n_lin++;
          default:       n_unknown++;
        endcase
        if (pred.last) n_wrap++;
        if (pred.status == STAT_PAST_END) n_past_end++;
        if (pred.status == STAT_RANGE) n_range++;
      end
      if (out_valid && !out_stall) begin
        results_seen++;
        if (expected_results.size() == 0) begin
          mismatches++;
          if (mismatches <= MAX_SHOWN)
            $display("tb: unexpected result %s", fmt_result(out_data));
        end else begin
          want = expected_results.pop_front();
          if (out_data.out_index_0 !== want.out_index_0 ||
              out_data.out_index_1 !== want.out_index_1 ||
              out_data.out_index_2 !== want.out_index_2 ||
              out_data.out_index_3 !== want.out_index_3 ||
              out_data.linear_offset !== want.linear_offset ||
              out_data.status !== want.status ||
              out_data.last !== want.last) begin
            mismatches++;
            if (mismatches <= MAX_SHOWN) begin
              $display("tb: mismatch on result %0d", results_seen);
              $display("tb:   expected %s", fmt_result(want));
              $display("tb:   actual   %s", fmt_result(out_data));
            end
          end
        end
      end
      if ((in_valid && !in_stall) || (out_valid && !out_stall))
        stuck_cycles = 0;
      else
        stuck_cycles++;
    end
  end

  initial begin : watchdog
    while (stuck_cycles < STUCK_LIMIT) @(posedge clk);
    $display("tb: no handshake for %0d cycles", STUCK_LIMIT);
    $display("tb: failure");
    $finish;
  end

  function automatic logic [63:0] dim_geom(logic [15:0] sz, logic [15:0] st,
                                           logic [15:0] sp, logic [15:0] sd);
    return {sz, st, sp, sd};
  endfunction

  function automatic logic [63:0] rand_geom();
    logic [15:0] st;
    logic [15:0] sp;
    logic [15:0] sd;
    logic [15:0] sz;
    if ($urandom_range(99) < 8) return {$urandom, $urandom};
    if ($urandom_range(99) < 15) st = 16'($urandom);
    else st = 16'($urandom_range(0, 7));
    sp = st + 16'($urandom_range(0, 3));
    case ($urandom_range(9))
      0:       sd = 16'd0;
      1:       sd = 16'($urandom);
      default: sd = 16'($urandom_range(1, 2));
    endcase
    if ($urandom_range(99) < 10) sz = 16'hFFFF;
    else sz = 16'($urandom_range(0, 12));
    return {sz, st, sp, sd};
  endfunction

  // half the time inside the dimension, otherwise anything
  function automatic logic [15:0] pick_index(int d);
    if (plan_size[d] != 16'd0 && $urandom_range(1) == 1)
      return 16'($urandom_range(0, plan_size[d] - 1));
    return 16'($urandom);
  endfunction

  task automatic push_item(logic [1:0] req, logic [15:0] i0, logic [15:0] i1,
                           logic [15:0] i2, logic [15:0] i3, logic chk);
    in_item_t it;
    it.req_type    = req;
    it.index_0     = i0;
    it.index_1     = i1;
    it.index_2     = i2;
    it.index_3     = i3;
    it.check_range = chk;
    pending_items = {pending_items, it};
  endtask

  task automatic push_lin();
    push_item(REQ_LINEARIZE, pick_index(0), pick_index(1), pick_index(2), pick_index(3),
              1'($urandom_range(0, 1)));
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= data;
  endtask

  task automatic configure(logic [2:0] nd, logic [63:0] g0, logic [63:0] g1,
                           logic [63:0] g2, logic [63:0] g3);
    logic [3:0][63:0] g;
    g = {g3, g2, g1, g0};
    // upper bits of the count register are don't-care
    write_reg(CFG_NUM_DIMS, {32'($urandom), 29'($urandom), nd});
    for (int d = 0; d < DIM_SLOTS; d++) begin
      write_reg(CFG_IDX_W'(CFG_DIM0 + d), g[d]);
      plan_size[d] = g[d][63:48];
    end
    // index past the register map, must be ignored
    write_reg(CFG_IDX_W'($urandom_range(5, 7)), {$urandom, $urandom});
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic wait_drained();
    while (pending_items.size() != 0 || in_valid || expected_results.size() != 0)
      @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  initial begin : stimulus
    int cnt;
    int len;
    logic [2:0] nd;
    for (int d = 0; d < DIM_SLOTS; d++) plan_size[d] = 16'd0;
    repeat (9) @(negedge clk);
    rst_n <= 1'b1;

    // reset state: iterator at end, one dimension of size zero
    push_item(REQ_STEP, 16'd0, 16'd0, 16'd0, 16'd0, 1'b0);
    push_item(REQ_LINEARIZE, 16'd0, 16'd0, 16'd0, 16'd0, 1'b1);
    push_item(REQ_LINEARIZE, 16'd0, 16'd0, 16'd0, 16'd0, 1'b0);
    push_item(REQ_RESTART, 16'd0, 16'd0, 16'd0, 16'd0, 1'b0);
    push_item(REQ_STEP, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 1'b1);
    push_item(REQ_UNKNOWN, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 1'b1);
    wait_drained();

    // four dimensions: wide stride sums, start above stop, full iteration
    configure(3'd4,
              dim_geom(16'd2, 16'd0, 16'd1, 16'd1),
              dim_geom(16'hFFFF, 16'hFFFE, 16'hFFFF, 16'hFFFF),
              dim_geom(16'd3, 16'd5, 16'd2, 16'd1),
              dim_geom(16'hFFFF, 16'd0, 16'hFFFF, 16'h8000));
    push_item(REQ_RESTART, 16'd0, 16'd0, 16'd0, 16'd0, 1'b1);
    repeat (5) push_item(REQ_STEP, 16'd0, 16'd0, 16'd0, 16'd0, 1'b0);
    push_item(REQ_LINEARIZE, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 1'b0);
    push_item(REQ_LINEARIZE, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 1'b1);
    push_item(REQ_LINEARIZE, 16'd1, 16'hFFFE, 16'd2, 16'hFFFE, 1'b1);
    push_item(REQ_RESTART, 16'd0, 16'd0, 16'd0, 16'd0, 1'b0);
    push_item(REQ_STEP, 16'd0, 16'd0, 16'd0, 16'd0, 1'b0);
    wait_drained();

    // zero stride never wraps
    configure(3'd2,
              dim_geom(16'd0, 16'd3, 16'd3, 16'd0),
              dim_geom(16'hFFFF, 16'd0, 16'd5, 16'd0),
              dim_geom(16'd0, 16'd0, 16'd0, 16'd0),
              dim_geom(16'd0, 16'd0, 16'd0, 16'd0));
    push_item(REQ_RESTART, 16'd0, 16'd0, 16'd0, 16'd0, 1'b0);
    repeat (3) push_item(REQ_STEP, 16'd0, 16'd0, 16'd0, 16'd0, 1'b0);
    push_item(REQ_LINEARIZE, 16'd2, 16'd7, 16'd0, 16'd0, 1'b1);

    for (int ph = 0; ph < RAND_PHASES; ph++) begin
      wait_drained();
      calm = (ph == 3);
      if (ph == 0) nd = 3'd0;
      else if (ph == 1) nd = 3'd7;
      else if (ph == 2) nd = 3'd4;
      else nd = 3'($urandom_range(0, 7));
      configure(nd, rand_geom(), rand_geom(), rand_geom(), rand_geom());
      cnt = 0;
      while (cnt < PHASE_ITEMS) begin
        if ($urandom_range(99) < 80) begin
          push_item(REQ_RESTART, 16'($urandom), 16'($urandom), 16'($urandom),
                    16'($urandom), 1'($urandom_range(0, 1)));
          cnt++;
          len = $urandom_range(1, 30);
          repeat (len) begin
            if ($urandom_range(99) < 20)
              push_lin();
            else
              push_item(REQ_STEP, 16'($urandom), 16'($urandom), 16'($urandom),
                        16'($urandom), 1'($urandom_range(0, 1)));
            cnt++;
          end
        end else begin
          push_item(2'($urandom_range(0, 3)), 16'($urandom), 16'($urandom),
                    16'($urandom), 16'($urandom), 1'($urandom_range(0, 1)));
          cnt++;
        end
      end
      if (ph == 5) begin
        // sender holds off until the block has emptied
        while (pending_items.size() > PHASE_ITEMS / 2) @(posedge clk);
        hold_in = 1'b1;
        while (in_valid || expected_results.size() != 0) @(posedge clk);
        repeat ($urandom_range(5, 30)) @(posedge clk);
        hold_in = 1'b0;
      end
    end
    wait_drained();
    repeat (20) @(posedge clk);

    $display("tb: %0d restarts, %0d steps (%0d wrapped, %0d past end), %0d linearizes",
             n_restart, n_step, n_wrap, n_past_end, n_lin);
    $display("tb: %0d out of range, %0d unknown, %0d results, %0d register writes",
             n_range, n_unknown, results_seen, cfg_writes);
    if (mismatches == 0 && expected_results.size() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: %0d mismatches", mismatches);
      $display("tb: failure");
    end
    $finish;
  end

endmodule
